/* design/blockwise_crc32_checker_unit_defines.svh */
// ---------------------------------------------------------------------------
// Blockwise CRC-32 checker assertion macros
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef BLOCKWISE_CRC32_CHECKER_UNIT_DEFINES_SVH
`define BLOCKWISE_CRC32_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define BCRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcrc assertion failed");

// next-cycle implication
`define BCRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcrc assertion failed");

`endif

/* design/bcrc_pkg.sv */
// ---------------------------------------------------------------------------
// Blockwise CRC-32 checker package
// Beat types, register indexes, constants and the byte-wise CRC update.
// ---------------------------------------------------------------------------
package bcrc_pkg;

   localparam logic [31:0] CRC_POLY        = 32'h04C1_1DB7;
   localparam logic [31:0] ZERO_CRC_SUBST  = 32'h5B63_7EB3;
   localparam logic [15:0] DEFAULT_BLK_LEN = 16'd4096;

   typedef enum logic {
      CSR_BLOCK_LENGTH    = 1'b0,
      CSR_ZERO_SUBSTITUTE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        end_of_data;
      logic [31:0] expected_crc;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] block_crc;
      logic [15:0] block_number;
      logic        crc_match;
      logic        final_block;
   } rsp_payload_type;

   // MSB-first, one bit per step
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {data, 24'h000000};
      for (int b = 0; b < 8; b++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* design/bcrc_rsp_buffer.sv */
// ---------------------------------------------------------------------------
// Blockwise CRC-32 checker result buffer
// Output register with one skid entry; full only when both are occupied.
// ---------------------------------------------------------------------------
module bcrc_rsp_buffer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bcrc_pkg::rsp_payload_type push_data,
   output logic                      full,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bcrc_pkg::rsp_payload_type rsp_payload
);
   import bcrc_pkg::*;

   logic            out_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || !rsp_stall) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               out_data_ff   <= skid_data_ff;
               skid_valid_ff <= push;
               skid_data_ff  <= push_data;
            end else begin
               out_valid_ff <= push;
               out_data_ff  <= push_data;
            end
         end else if (push) begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= push_data;
         end
      end
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

/* design/blockwise_crc32_checker_unit.sv */
// ---------------------------------------------------------------------------
// Blockwise CRC-32 checker
// Result: on acceptance, a closing beat's result is registered in the result buffer.
// Throughput: one byte beat per cycle; the running CRC is one byte-wide
// update between the state registers. Stalls only when two results wait.
// Reset: synchronous, active high; block length 4096, no substitution.
// ---------------------------------------------------------------------------
module blockwise_crc32_checker_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bcrc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bcrc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [15:0]               csr_write_data
);
   import bcrc_pkg::*;

   logic [15:0]     blk_len_ff;
   logic            zero_sub_ff;
   logic [31:0]     crc_ff;
   logic [31:0]     crc_in;
   logic [15:0]     count_ff;
   logic [15:0]     blk_idx_ff;
   logic [16:0]     count_next;
   logic [16:0]     limit;
   logic            accept;
   logic            close;
   logic [31:0]     crc_out;
   logic            buf_full;
   rsp_payload_type result;

   assign accept     = req_valid && !req_stall;
   assign crc_in     = crc_byte(crc_ff, req_payload.data_byte);
   assign count_next = {1'b0, count_ff} + 17'd1;
   assign limit      = (blk_len_ff == 16'd0) ? 17'h10000 : {1'b0, blk_len_ff};
   assign close      = req_payload.end_of_data || (count_next >= limit);

   always_comb begin
      crc_out = crc_in;
      if (zero_sub_ff && (crc_in == 32'd0)) begin
         crc_out = ZERO_CRC_SUBST;
      end
      result.block_crc    = crc_out;
      result.block_number = blk_idx_ff;
      result.crc_match    = (crc_out == req_payload.expected_crc);
      result.final_block  = req_payload.end_of_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_len_ff  <= DEFAULT_BLK_LEN;
         zero_sub_ff <= 1'b0;
         crc_ff      <= 32'd0;
         count_ff    <= 16'd0;
         blk_idx_ff  <= 16'd0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_BLOCK_LENGTH:    blk_len_ff  <= csr_write_data;
               CSR_ZERO_SUBSTITUTE: zero_sub_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            if (close) begin
               crc_ff     <= 32'd0;
               count_ff   <= 16'd0;
               blk_idx_ff <= req_payload.end_of_data ? 16'd0 : blk_idx_ff + 16'd1;
            end else begin
               crc_ff   <= crc_in;
               count_ff <= count_next[15:0];
            end
         end
      end
   end

   assign req_stall = buf_full;

   bcrc_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .push        (accept && close),
      .push_data   (result),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* design/bcrc_checker.sv */
// ---------------------------------------------------------------------------
// Blockwise CRC-32 checker port assertions
// Watches the top-level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
`include "blockwise_crc32_checker_unit_defines.svh"

module bcrc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input bcrc_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input bcrc_pkg::rsp_payload_type rsp_payload,
   input logic                      csr_write_enable,
   input logic                      csr_index,
   input logic [15:0]               csr_write_data
);
   import bcrc_pkg::*;

   `BCRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `BCRC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))
   // upstream only held off while a result waits
   `BCRC_ASSERT_IMPLY(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid)
   // reset empties the result path
   `BCRC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind blockwise_crc32_checker_unit bcrc_checker u_bcrc_checker (.*);

/* tb/sv/blockwise_crc32_checker_unit_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Blockwise CRC-32 checker testbench
// Drives byte beats into the checker under random sender gaps and receiver
// stalls, folds every accepted byte into a local CRC-32 model and compares
// each closed-block result, field by field, against the oldest prediction.
// Covers field extremes, zero-CRC substitution, restart after end of data,
// block length changes mid-block, a block length of 65535 and a
// long receiver hold-off that backs up the input.
// ---------------------------------------------------------------------------
module blockwise_crc32_checker_unit_test;
   import bcrc_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_RARE,
      STALL_PERIODIC
   } stall_pattern_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic            csr_index = CSR_BLOCK_LENGTH;
   logic [15:0]     csr_write_data = '0;

   // local model of the checker
   logic [31:0] model_crc;
   logic [15:0] model_byte_count;
   logic [15:0] model_block_number;
   logic [15:0] model_block_length;
   logic        model_zero_subst;

   rsp_payload_type closed_blocks[$];
   int              failures = 0;
   int              cycle_count = 0;

   bit                sender_gaps_on = 1'b1;
   int                burst_left = 0;
   bit                hold_off_request = 1'b0;
   int                hold_off_left = 0;
   stall_pattern_type stall_pattern = STALL_NONE;
   int                pattern_left = 0;

   always #4 clock = ~clock;

   blockwise_crc32_checker_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shift register form: feedback is the top bit xor the incoming data bit
   function automatic logic [31:0] fold_crc_byte(input logic [31:0] acc,
                                                 input logic [7:0] data);
      logic [31:0] c;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
         c = {c[30:0], 1'b0} ^ ((c[31] ^ data[i]) ? CRC_POLY : 32'h0000_0000);
      end
      return c;
   endfunction

   function automatic logic [31:0] reported_crc(input logic [31:0] raw);
      return (model_zero_subst && raw == 32'h0) ? ZERO_CRC_SUBST : raw;
   endfunction

   function automatic void fold_beat(input req_payload_type beat);
      logic [16:0]     count;
      logic [16:0]     blk_limit;
      rsp_payload_type res;
      model_crc = fold_crc_byte(model_crc, beat.data_byte);
      count = {1'b0, model_byte_count} + 17'd1;
      blk_limit = (model_block_length == 16'd0) ? 17'd65536 : {1'b0, model_block_length};
      if (!beat.end_of_data && count < blk_limit) begin
         model_byte_count = count[15:0];
      end else begin
         res.block_crc    = reported_crc(model_crc);
         res.block_number = model_block_number;
         res.crc_match    = (res.block_crc == beat.expected_crc);
         res.final_block  = beat.end_of_data;
         closed_blocks.push_back(res);
         model_crc = '0;
         model_byte_count = '0;
         model_block_number = beat.end_of_data ? 16'd0 : model_block_number + 16'd1;
      end
   endfunction

   function automatic void check_block(input rsp_payload_type got);
      rsp_payload_type want;
      if (closed_blocks.size() == 0) begin
         failures++;
         $error("unexpected result beat: %p", got);
         return;
      end
      want = closed_blocks.pop_front();
      if (got.block_crc !== want.block_crc) begin
         failures++;
         $error("block_crc: expected %h, actual %h", want.block_crc, got.block_crc);
      end
      if (got.block_number !== want.block_number) begin
         failures++;
         $error("block_number: expected %0d, actual %0d", want.block_number,
                got.block_number);
      end
      if (got.crc_match !== want.crc_match) begin
         failures++;
         $error("crc_match: expected %b, actual %b", want.crc_match, got.crc_match);
      end
      if (got.final_block !== want.final_block) begin
         failures++;
         $error("final_block: expected %b, actual %b", want.final_block, got.final_block);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         model_crc          = '0;
         model_byte_count   = '0;
         model_block_number = '0;
         model_block_length = DEFAULT_BLK_LEN;
         model_zero_subst   = 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_BLOCK_LENGTH) begin
               model_block_length = csr_write_data;
            end else begin
               model_zero_subst = csr_write_data[0];
            end
         end
         if (req_valid && !req_stall) begin
            fold_beat(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            check_block(rsp_payload);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("blockwise_crc32_checker_unit_test: errors");
         $finish;
      end
   end

   // receiver: changing stall patterns, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_off_left = 300;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 300);
         end
         pattern_left--;
         case (stall_pattern)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_HALF:     rsp_stall <= 1'($urandom_range(0, 1));
            STALL_RARE:     rsp_stall <= ($urandom_range(0, 9) == 0);
            STALL_PERIODIC: rsp_stall <= ((pattern_left % 5) < 2);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // expected_crc is filled in late so that it sees the model after the
   // previous beat
   task automatic send_beat(input req_payload_type beat, input bit want_match);
      int gap;
      @(negedge clock);
      if (sender_gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      if (want_match) beat.expected_crc = reported_crc(fold_crc_byte(model_crc, beat.data_byte));
      req_payload <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_byte(input logic [7:0] data, input bit last,
                            input logic [31:0] exp_crc, input bit want_match);
      req_payload_type beat;
      beat.data_byte    = data;
      beat.end_of_data  = last;
      beat.expected_crc = exp_crc;
      send_beat(beat, want_match);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (closed_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_zero_crc();
      // reset settings: 4096-byte blocks, no substitution
      send_byte(8'h00, 1'b1, 32'h0, 1'b0);
      settle();
      write_reg(CSR_ZERO_SUBSTITUTE, 16'd1);
      send_byte(8'h00, 1'b1, ZERO_CRC_SUBST, 1'b0);
      send_byte(8'h00, 1'b1, 32'h0, 1'b0);
   endtask

   task automatic test_field_extremes();
      settle();
      write_reg(CSR_ZERO_SUBSTITUTE, 16'd0);
      write_reg(CSR_BLOCK_LENGTH, 16'd3);
      send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
      send_byte(8'h00, 1'b0, 32'h0, 1'b0);
      send_byte(8'hFF, 1'b0, 32'h0, 1'b1);
      send_byte(8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
   endtask

   task automatic test_restart_after_end();
      settle();
      write_reg(CSR_BLOCK_LENGTH, 16'd2);
      repeat (5) send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom, 1'b1);
      send_byte(8'($urandom_range(0, 255)), 1'b1, $urandom, 1'b1);
      repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom, 1'b0);
   endtask

   task automatic test_length_lowered();
      settle();
      write_reg(CSR_BLOCK_LENGTH, 16'd100);
      repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom, 1'b0);
      settle();
      write_reg(CSR_BLOCK_LENGTH, 16'd4);
      send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom, 1'b1);
   endtask

   task automatic test_longest_length();
      settle();
      write_reg(CSR_BLOCK_LENGTH, 16'hFFFF);
      send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom, 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1, $urandom, 1'b1);
   endtask

   task automatic test_random_stream();
      int              sent;
      int              pick;
      int              phase_len;
      bit              zero_heavy;
      logic [15:0]     blk_len;
      req_payload_type beat;
      sent = 0;
      while (sent < 1550) begin
         settle();
         pick = $urandom_range(0, 19);
         if (pick == 0) blk_len = 16'd0;
         else if (pick == 1) blk_len = 16'hFFFF;
         else if (pick < 5) blk_len = 16'd1;
         else blk_len = 16'($urandom_range(2, 40));
         write_reg(CSR_BLOCK_LENGTH, blk_len);
         write_reg(CSR_ZERO_SUBSTITUTE, 16'($urandom_range(0, 1)));
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         zero_heavy = ($urandom_range(0, 4) == 0);
         phase_len = $urandom_range(40, 120);
         repeat (phase_len) begin
            if (zero_heavy && $urandom_range(0, 3) != 0) beat.data_byte = 8'h00;
            else beat.data_byte = 8'($urandom_range(0, 255));
            beat.end_of_data  = ($urandom_range(0, 29) == 0);
            beat.expected_crc = $urandom;
            send_beat(beat, $urandom_range(0, 2) == 0);
            sent++;
         end
      end
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      settle();
      write_reg(CSR_BLOCK_LENGTH, 16'd1);
      sender_gaps_on = 1'b0;
      hold_off_request = 1'b1;
      repeat (80) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, $urandom,
                            1'($urandom_range(0, 1)));
      sender_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_zero_crc();
      test_field_extremes();
      test_restart_after_end();
      test_length_lowered();
      test_longest_length();
      test_random_stream();
      test_backpressure();
      settle();
      repeat (8) @(posedge clock);
      if (failures == 0 && closed_blocks.size() == 0) begin
         $display("blockwise_crc32_checker_unit_test: clean");
      end else begin
         $display("blockwise_crc32_checker_unit_test: errors");
      end
      $finish;
   end

endmodule
